// ===== hdl/infix_to_postfix_converter_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the infix to postfix converter
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

`define ITPC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ITPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ITPC_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ITPC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/itpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter package
// Beat types, token codes, stack entry layout and operator precedence.
// ----------------------------------------------------------------------------
`default_nettype none

package itpc_pkg;

   localparam int STACK_DEPTH  = 32;
   localparam int PAYLOAD_BITS = 32;
   localparam int ADDR_BITS    = $clog2(STACK_DEPTH);
   localparam int CNT_BITS     = $clog2(STACK_DEPTH + 1);

   localparam logic [CNT_BITS-1:0] STACK_FULL = CNT_BITS'(STACK_DEPTH);

   typedef enum logic [2:0] {
      TK_NUMBER = 3'd0,
      TK_CELL   = 3'd1,
      TK_FUNC   = 3'd2,
      TK_OPER   = 3'd3,
      TK_LPAREN = 3'd4,
      TK_RPAREN = 3'd5,
      TK_COMMA  = 3'd6,
      TK_END    = 3'd7
   } token_kind_type;

   typedef enum logic [1:0] {
      OK_NUMBER = 2'd0,
      OK_CELL   = 2'd1,
      OK_FUNC   = 2'd2,
      OK_OPER   = 2'd3
   } out_kind_type;

   typedef enum logic [2:0] {
      ST_TOKEN    = 3'd0,
      ST_DONE     = 3'd1,
      ST_PAREN    = 3'd2,
      ST_COMMA    = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ENT_FUNC = 2'd0,
      ENT_OPER = 2'd1,
      ENT_LPAR = 2'd2
   } ent_kind_type;

   typedef struct packed {
      logic [2:0]              token_kind;
      logic [2:0]              op_code;
      logic [PAYLOAD_BITS-1:0] token_payload;
   } req_type;

   typedef struct packed {
      logic [1:0]              out_kind;
      logic [2:0]              out_op;
      logic [PAYLOAD_BITS-1:0] out_payload;
      logic [2:0]              status;
      logic                    last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]              kind;
      logic [2:0]              op;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   typedef struct packed {
      logic                 wr_en;
      logic [ADDR_BITS-1:0] wr_addr;
      logic                 rd_en;
      logic [ADDR_BITS-1:0] rd_addr;
   } ram_ctrl_type;

   function automatic logic [1:0] prec_of(input logic [2:0] op);
      logic [1:0] p;
      case (op)
         3'd0, 3'd1: p = 2'd1;
         3'd2, 3'd3: p = 2'd2;
         default:    p = 2'd3;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/itpc_stack_ram.sv =====
// ----------------------------------------------------------------------------
// Operator stack memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module itpc_stack_ram (
   input  wire logic                 clock,
   input  wire itpc_pkg::ram_ctrl_type ctrl,
   input  wire itpc_pkg::entry_type  wr_data,
   output      itpc_pkg::entry_type  rd_data
);

   itpc_pkg::entry_type mem [itpc_pkg::STACK_DEPTH];
   itpc_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/infix_to_postfix_converter_core.sv =====
// ----------------------------------------------------------------------------
// Infix to postfix converter core
// Shunting-yard reordering of formula tokens over a stack in memory.
// ----------------------------------------------------------------------------
// req_* takes one token per beat; rsp_* gives postfix tokens, done markers
// and error beats, with last set on the final beat caused by a token.
// Tokens that are only pushed (function, left parenthesis, operator that
// pops nothing) cause no rsp beat.
// A function or left parenthesis is pushed when it is accepted. Each stack
// inspection issues the address, then uses the registered read data of the
// stack memory; a check of an empty stack needs no read.
// req_ready is high only while the sequencer is idle.
// A result is held one beat back until the next one is known, so last can
// be set; the output register lets the next result be formed while rsp_ready
// is low, and the sequencer holds when both are full.
// An error beat clears the stack. Reset empties the stack and drops any
// result not yet taken; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "infix_to_postfix_converter_core_assert.svh"

module infix_to_postfix_converter_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire itpc_pkg::req_type req_data,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      itpc_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_EVAL  = 4'b0100,
      S_FLUSH = 4'b1000
   } state_type;

   state_type                           state_ff, state_in, nxt_state;
   logic [itpc_pkg::CNT_BITS-1:0]       count_ff, count_in, nxt_count, cnt_dec;
   logic                                fn_ff, fn_in, nxt_fn;
   itpc_pkg::req_type                   tok_ff, tok_in;
   itpc_pkg::rsp_type                   pend_ff, pend_in;
   logic                                pend_valid_ff, pend_valid_in;
   itpc_pkg::rsp_type                   rsp_ff, rsp_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   itpc_pkg::ram_ctrl_type              ram_ctrl;
   itpc_pkg::entry_type                 ram_rd_data;
   itpc_pkg::entry_type                 push_entry;
   logic                                push_en;

   logic                                stack_empty, stack_full, rsp_free, commit;
   logic                                eval_en, res_req, rsp_load, rsp_last;
   logic                                num_accept;
   itpc_pkg::rsp_type                   res_val, pop_val, tok_val;

   itpc_stack_ram u_stack (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .wr_data (push_entry),
      .rd_data (ram_rd_data)
   );

   assign stack_empty = (count_ff == '0);
   assign stack_full  = (count_ff == itpc_pkg::STACK_FULL);
   assign cnt_dec     = count_ff - 1'b1;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign eval_en     = (state_ff == S_EVAL) || ((state_ff == S_READ) && stack_empty);

   always_comb begin
      pop_val        = '0;
      pop_val.status = itpc_pkg::ST_TOKEN;
      if (ram_rd_data.kind == itpc_pkg::ENT_FUNC) begin
         pop_val.out_kind    = itpc_pkg::OK_FUNC;
         pop_val.out_payload = ram_rd_data.payload;
      end else begin
         pop_val.out_kind = itpc_pkg::OK_OPER;
         pop_val.out_op   = ram_rd_data.op;
      end
      tok_val             = '0;
      tok_val.out_kind    = req_data.token_kind[1:0];
      tok_val.out_payload = req_data.token_payload;
      tok_val.status      = itpc_pkg::ST_TOKEN;
   end

   always_comb begin
      nxt_state        = state_ff;
      nxt_count        = count_ff;
      nxt_fn           = fn_ff;
      tok_in           = tok_ff;
      res_req          = 1'b0;
      res_val          = '0;
      push_en          = 1'b0;
      push_entry       = '0;
      rsp_last         = 1'b0;
      ram_ctrl.rd_en   = 1'b0;
      ram_ctrl.rd_addr = cnt_dec[itpc_pkg::ADDR_BITS-1:0];
      ram_ctrl.wr_addr = count_ff[itpc_pkg::ADDR_BITS-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               tok_in = req_data;
               unique case (req_data.token_kind) inside
                  itpc_pkg::TK_NUMBER, itpc_pkg::TK_CELL: begin
                     res_req   = 1'b1;
                     res_val   = tok_val;
                     nxt_state = S_FLUSH;
                  end
                  itpc_pkg::TK_FUNC, itpc_pkg::TK_LPAREN: begin
                     if (stack_full) begin
                        res_req        = 1'b1;
                        res_val.status = itpc_pkg::ST_OVERFLOW;
                        nxt_count      = '0;
                        nxt_state      = S_FLUSH;
                     end else begin
                        push_en = 1'b1;
                        if (req_data.token_kind == itpc_pkg::TK_FUNC) begin
                           push_entry.kind    = itpc_pkg::ENT_FUNC;
                           push_entry.payload = req_data.token_payload;
                        end else begin
                           push_entry.kind = itpc_pkg::ENT_LPAR;
                        end
                        nxt_count = count_ff + 1'b1;
                     end
                  end
                  default: begin
                     nxt_fn    = 1'b0;
                     nxt_state = S_READ;
                  end
               endcase
            end
         end
         S_READ: begin
            if (!stack_empty) begin
               ram_ctrl.rd_en = 1'b1;
               nxt_state      = S_EVAL;
            end
         end
         S_EVAL: begin
            nxt_state = S_EVAL;
         end
         S_FLUSH: begin
            if (!pend_valid_ff || rsp_free) begin
               rsp_last  = 1'b1;
               nxt_state = S_IDLE;
            end
         end
         default: begin
            nxt_state = S_IDLE;
         end
      endcase

      if (eval_en) begin
         unique case (tok_ff.token_kind)
            itpc_pkg::TK_OPER: begin
               if (!stack_empty && (ram_rd_data.kind == itpc_pkg::ENT_OPER) &&
                   (itpc_pkg::prec_of(ram_rd_data.op) >=
                    itpc_pkg::prec_of(tok_ff.op_code))) begin
                  res_req   = 1'b1;
                  res_val   = pop_val;
                  nxt_count = cnt_dec;
                  nxt_state = S_READ;
               end else if (stack_full) begin
                  res_req        = 1'b1;
                  res_val.status = itpc_pkg::ST_OVERFLOW;
                  nxt_count      = '0;
                  nxt_state      = S_FLUSH;
               end else begin
                  push_en         = 1'b1;
                  push_entry.kind = itpc_pkg::ENT_OPER;
                  push_entry.op   = tok_ff.op_code;
                  nxt_count       = count_ff + 1'b1;
                  nxt_state       = S_FLUSH;
               end
            end
            itpc_pkg::TK_RPAREN: begin
               if (fn_ff) begin
                  nxt_fn    = 1'b0;
                  nxt_state = S_FLUSH;
                  if (!stack_empty && (ram_rd_data.kind == itpc_pkg::ENT_FUNC)) begin
                     res_req   = 1'b1;
                     res_val   = pop_val;
                     nxt_count = cnt_dec;
                  end
               end else if (stack_empty) begin
                  res_req        = 1'b1;
                  res_val.status = itpc_pkg::ST_PAREN;
                  nxt_state      = S_FLUSH;
               end else if (ram_rd_data.kind == itpc_pkg::ENT_LPAR) begin
                  nxt_count = cnt_dec;
                  nxt_fn    = 1'b1;
                  nxt_state = S_READ;
               end else begin
                  res_req   = 1'b1;
                  res_val   = pop_val;
                  nxt_count = cnt_dec;
                  nxt_state = S_READ;
               end
            end
            itpc_pkg::TK_COMMA: begin
               if (stack_empty) begin
                  res_req        = 1'b1;
                  res_val.status = itpc_pkg::ST_COMMA;
                  nxt_state      = S_FLUSH;
               end else if (ram_rd_data.kind == itpc_pkg::ENT_LPAR) begin
                  nxt_state = S_FLUSH;
               end else begin
                  res_req   = 1'b1;
                  res_val   = pop_val;
                  nxt_count = cnt_dec;
                  nxt_state = S_READ;
               end
            end
            itpc_pkg::TK_END: begin
               if (stack_empty) begin
                  res_req        = 1'b1;
                  res_val.status = itpc_pkg::ST_DONE;
                  nxt_state      = S_FLUSH;
               end else if (ram_rd_data.kind == itpc_pkg::ENT_LPAR) begin
                  res_req        = 1'b1;
                  res_val.status = itpc_pkg::ST_PAREN;
                  nxt_count      = '0;
                  nxt_state      = S_FLUSH;
               end else begin
                  res_req   = 1'b1;
                  res_val   = pop_val;
                  nxt_count = cnt_dec;
                  nxt_state = S_READ;
               end
            end
            default: begin
               nxt_state = S_FLUSH;
            end
         endcase
      end

      ram_ctrl.wr_en = push_en;
   end

   always_comb begin
      commit        = !res_req || !pend_valid_ff || rsp_free;
      state_in      = state_ff;
      count_in      = count_ff;
      fn_in         = fn_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_load      = 1'b0;

      if (commit) begin
         state_in = nxt_state;
         count_in = nxt_count;
         fn_in    = nxt_fn;
         if (res_req) begin
            rsp_load      = pend_valid_ff;
            pend_in       = res_val;
            pend_valid_in = 1'b1;
         end
      end
      if ((state_ff == S_FLUSH) && pend_valid_ff && rsp_free) begin
         rsp_load      = 1'b1;
         pend_valid_in = 1'b0;
      end

      rsp_in      = pend_ff;
      rsp_in.last = rsp_last;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         fn_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         fn_ff         <= fn_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      pend_ff <= pend_in;
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign num_accept = req_valid && req_ready &&
                       (req_data.token_kind == itpc_pkg::TK_NUMBER);

   `ITPC_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= itpc_pkg::STACK_FULL)
   `ITPC_ASSERT_IMPLIES(a_idle_no_pend, clock, reset, state_ff == S_IDLE, !pend_valid_ff)
   `ITPC_ASSERT_IMPLIES(a_load_when_free, clock, reset, rsp_load, rsp_free)
   `ITPC_ASSERT_NEXT(a_pass_through, clock, reset, num_accept, (state_ff == S_FLUSH) && pend_valid_ff)

endmodule

`default_nettype wire
